@@ rtl/dat_pkg.sv @@
// Package for the disk adapter: payload types, register offsets and constants.
`timescale 1ns / 1ps
`default_nettype none
package dat_pkg;

  // Head position at which the drive stops
  localparam int unsigned DISK_BYTES = 65500;

  localparam int unsigned SPINUP_W  = 14;
  localparam int unsigned BYTEDLY_W = 10;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [SPINUP_W-1:0]  SPINUP_RESET  = 14'd10000;
  localparam logic [BYTEDLY_W-1:0] BYTEDLY_RESET = 10'd149;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPINUP_DELAY = 1'b0,
    CFG_BYTE_DELAY   = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2
  } mode_e;

  // Bus write offsets
  localparam logic [4:0] OFF_RELOAD_LO = 5'd0;
  localparam logic [4:0] OFF_RELOAD_HI = 5'd1;
  localparam logic [4:0] OFF_TIMER_CTL = 5'd2;
  localparam logic [4:0] OFF_IO_ENABLE = 5'd3;
  localparam logic [4:0] OFF_WR_LATCH  = 5'd4;
  localparam logic [4:0] OFF_CONTROL   = 5'd5;
  localparam logic [4:0] OFF_EXT_WR    = 5'd6;
  // Bus read offsets
  localparam logic [4:0] OFF_STATUS    = 5'd16;
  localparam logic [4:0] OFF_DATA      = 5'd17;
  localparam logic [4:0] OFF_DRIVE     = 5'd18;
  localparam logic [4:0] OFF_EXT_RD    = 5'd19;

  // Read values
  localparam logic [7:0] STAT_BASE      = 8'h80;
  localparam logic [7:0] STAT_TIMER     = 8'h01;
  localparam logic [7:0] STAT_XFER      = 8'h02;
  localparam logic [7:0] STAT_EOD       = 8'h40;
  localparam logic [7:0] DRV_BASE       = 8'h40;
  localparam logic [7:0] DRV_NO_DISK    = 8'h07;
  localparam logic [7:0] DRV_NOT_READY  = 8'h02;
  localparam logic [7:0] EXT_READ_VALUE = 8'h80;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] reg_offset;
    logic [7:0] write_data;
    logic [7:0] disk_byte;
    logic       disk_present;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        timer_irq;
    logic        transfer_irq;
    logic        disk_write_enable;
    logic [15:0] disk_write_address;
    logic [7:0]  disk_write_data;
    logic [15:0] head_position;
    logic        mirror_vertical;
    logic [7:0]  ext_port;
  } out_item_t;

  typedef struct packed {
    logic motor;
    logic no_scan;
    logic in_data;
    logic write_mode;
    logic xirq_en;
    logic tirq_en;
    logic reload;
    logic xfer;
    logic scan;
    logic skipped;
    logic eod;
    logic crc;
    logic mirv;
  } drive_flags_t;

endpackage
`default_nettype wire

@@ rtl/disk_adapter_timer_and_transfer.sv @@
// Disk adapter top level: interval timer, drive transfer engine and bus registers.
`timescale 1ns / 1ps
`default_nettype none
// Takes one item (tick, bus read or bus write) per clock while results are taken
// and returns one result per item, in order. An accepted item sits in an input
// register; the whole state update for it is done as it leaves that register and
// its result lands in the output register, from which it is offered. The sustained
// rate is one item per cycle as long as results are taken. The output register
// holds a result while the consumer stalls, and the input register keeps
// accepting until it is full. Configuration writes are always ready.
module disk_adapter_timer_and_transfer (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  dat_pkg::in_item_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output dat_pkg::out_item_t                 out_data_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [dat_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire  [dat_pkg::SPINUP_W-1:0]       cfg_data_i
);
  import dat_pkg::*;

  logic                 in_valid_q;
  in_item_t             in_data_q;
  logic                 out_valid_q;
  out_item_t            out_data_q, out_data_d;
  logic                 advance;

  logic [SPINUP_W-1:0]  spinup_q;
  logic [BYTEDLY_W-1:0] byte_delay_q;

  logic [15:0]          head_q, head_d;
  logic [SPINUP_W-1:0]  wait_q, wait_d;
  logic [15:0]          reload_q, reload_d;
  logic [15:0]          timer_q, timer_d;
  logic [7:0]           ext_q, ext_d;
  logic [7:0]           rlatch_q, rlatch_d;
  logic [7:0]           wlatch_q, wlatch_d;
  drive_flags_t         fl_q, fl_d;
  logic                 irq_t_q, irq_t_d;
  logic                 irq_x_q, irq_x_d;

  logic [7:0]           rd;
  logic                 we;
  logic [15:0]          wa;
  logic [7:0]           wd;
  logic [16:0]          next_pos;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;
  assign next_pos    = {1'b0, head_q} + 17'd1;

  always_comb begin
    head_d   = head_q;
    wait_d   = wait_q;
    reload_d = reload_q;
    timer_d  = timer_q;
    ext_d    = ext_q;
    rlatch_d = rlatch_q;
    wlatch_d = wlatch_q;
    fl_d     = fl_q;
    irq_t_d  = irq_t_q;
    irq_x_d  = irq_x_q;
    rd = '0;
    we = 1'b0;
    wa = '0;
    wd = '0;

    unique case (in_data_q.mode)
      MODE_TICK: begin
        if (fl_q.tirq_en) begin
          if (timer_q != 16'd0) begin
            timer_d = timer_q - 16'd1;
          end else begin
            irq_t_d = 1'b1;
            if (fl_q.reload) timer_d = reload_q;
            else fl_d.tirq_en = 1'b0;
          end
        end
        if (!fl_q.motor) begin
          fl_d.scan = 1'b0;
          fl_d.eod  = 1'b1;
        end else if (fl_q.no_scan && !fl_q.scan) begin
          // hold until scanning is enabled
        end else if (fl_q.eod) begin
          // head back to the disk start, then spin up
          fl_d.eod     = 1'b0;
          wait_d       = spinup_q;
          head_d       = '0;
          fl_d.skipped = 1'b0;
        end else if (wait_q != '0) begin
          wait_d = wait_q - 14'd1;
        end else begin
          fl_d.scan = 1'b1;
          if (!fl_q.write_mode) begin
            if (!fl_q.in_data) begin
              fl_d.skipped = 1'b0;
            end else if (in_data_q.disk_byte != 8'd0 && !fl_q.skipped) begin
              // first nonzero byte ends the gap and is dropped
              fl_d.skipped = 1'b1;
            end else if (fl_q.skipped) begin
              fl_d.xfer = 1'b1;
              rlatch_d  = in_data_q.disk_byte;
              if (fl_q.xirq_en) irq_x_d = 1'b1;
            end
          end else begin
            if (!fl_q.crc) begin
              fl_d.xfer = 1'b1;
              if (fl_q.xirq_en) irq_x_d = 1'b1;
            end
            we = 1'b1;
            wa = head_q;
            wd = fl_q.in_data ? wlatch_q : 8'd0;
            fl_d.skipped = 1'b0;
          end
          if (next_pos >= 17'(DISK_BYTES)) fl_d.motor = 1'b0;
          else wait_d = {{(SPINUP_W-BYTEDLY_W){1'b0}}, byte_delay_q};
          head_d = next_pos[15:0];
        end
      end
      MODE_READ: begin
        case (in_data_q.reg_offset)
          OFF_STATUS: begin
            rd = STAT_BASE;
            if (irq_t_q) rd = rd | STAT_TIMER;
            if (fl_q.xfer) rd = rd | STAT_XFER;
            if (fl_q.eod) rd = rd | STAT_EOD;
            fl_d.xfer = 1'b0;
            irq_t_d   = 1'b0;
            irq_x_d   = 1'b0;
          end
          OFF_DATA: begin
            rd        = rlatch_q;
            fl_d.xfer = 1'b0;
            irq_x_d   = 1'b0;
          end
          OFF_DRIVE: begin
            rd = DRV_BASE;
            if (!in_data_q.disk_present) rd = rd | DRV_NO_DISK;
            if (!fl_q.scan) rd = rd | DRV_NOT_READY;
          end
          OFF_EXT_RD: rd = EXT_READ_VALUE;
          default: rd = '0;
        endcase
      end
      MODE_WRITE: begin
        case (in_data_q.reg_offset)
          OFF_RELOAD_LO: reload_d = {reload_q[15:8], in_data_q.write_data};
          OFF_RELOAD_HI: reload_d = {in_data_q.write_data, reload_q[7:0]};
          OFF_TIMER_CTL: begin
            fl_d.reload  = in_data_q.write_data[0];
            fl_d.tirq_en = in_data_q.write_data[1];
            timer_d      = reload_q;
            if (!in_data_q.write_data[1]) irq_t_d = 1'b0;
          end
          OFF_IO_ENABLE: if (!in_data_q.write_data[0]) irq_t_d = 1'b0;
          OFF_WR_LATCH: begin
            irq_x_d   = 1'b0;
            fl_d.xfer = 1'b0;
            wlatch_d  = in_data_q.write_data;
          end
          OFF_CONTROL: begin
            fl_d.motor      = in_data_q.write_data[0];
            fl_d.no_scan    = in_data_q.write_data[1];
            fl_d.write_mode = !in_data_q.write_data[2];
            fl_d.mirv       = in_data_q.write_data[3];
            fl_d.crc        = in_data_q.write_data[4];
            fl_d.in_data    = in_data_q.write_data[6];
            fl_d.xirq_en    = in_data_q.write_data[7];
          end
          OFF_EXT_WR: ext_d = in_data_q.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase

    out_data_d.read_data          = rd;
    out_data_d.timer_irq          = irq_t_d;
    out_data_d.transfer_irq       = irq_x_d;
    out_data_d.disk_write_enable  = we;
    out_data_d.disk_write_address = wa;
    out_data_d.disk_write_data    = wd;
    out_data_d.head_position      = head_d;
    out_data_d.mirror_vertical    = fl_d.mirv;
    out_data_d.ext_port           = ext_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      spinup_q     <= SPINUP_RESET;
      byte_delay_q <= BYTEDLY_RESET;
      head_q       <= '0;
      wait_q       <= '0;
      reload_q     <= '0;
      timer_q      <= '0;
      ext_q        <= '0;
      rlatch_q     <= '0;
      wlatch_q     <= '0;
      fl_q         <= '0;
      irq_t_q      <= 1'b0;
      irq_x_q      <= 1'b0;
    end else begin
      if (in_ready_o) in_valid_q <= in_valid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SPINUP_DELAY: spinup_q <= cfg_data_i;
          CFG_BYTE_DELAY:   byte_delay_q <= cfg_data_i[BYTEDLY_W-1:0];
          default: ;
        endcase
      end
      if (advance) begin
        head_q   <= head_d;
        wait_q   <= wait_d;
        reload_q <= reload_d;
        timer_q  <= timer_d;
        ext_q    <= ext_d;
        rlatch_q <= rlatch_d;
        wlatch_q <= wlatch_d;
        fl_q     <= fl_d;
        irq_t_q  <= irq_t_d;
        irq_x_q  <= irq_x_d;
      end
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) in_data_q <= in_data_i;
    if (advance) out_data_q <= out_data_d;
  end

endmodule
`default_nettype wire

@@ rtl/dat_checker.sv @@
// Port-level checks for the disk adapter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module dat_checker (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           in_valid_i,
  input wire                           in_ready_o,
  input dat_pkg::in_item_t             in_data_i,
  input wire                           out_valid_o,
  input wire                           out_ready_i,
  input dat_pkg::out_item_t            out_data_o,
  input wire                           cfg_valid_i,
  input wire                           cfg_ready_o,
  input wire [dat_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input wire [dat_pkg::SPINUP_W-1:0]   cfg_data_i
);
  import dat_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Only ticks write the disk, and ticks read nothing
  a_we_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.disk_write_enable |-> out_data_o.read_data == 8'd0)
    else $error("disk write with nonzero read data");

  // Idle write port shows zero address and data
  a_we_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.disk_write_enable |->
      out_data_o.disk_write_address == 16'd0 && out_data_o.disk_write_data == 8'd0)
    else $error("disk write fields set without write enable");

  // A written byte advances the head by one
  a_we_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.disk_write_enable |->
      out_data_o.head_position == out_data_o.disk_write_address + 16'd1)
    else $error("head did not advance after disk write");

endmodule

bind disk_adapter_timer_and_transfer dat_checker u_dat_checker (.*);
`default_nettype wire
